// ===== src/afs_pkg.sv =====
// Shared types, codes and constants of the autofocus sweep sequencer.
`default_nettype none

package afs_pkg;

    // Fixed field widths.
    localparam int REQ_W    = 3;
    localparam int HFR_W    = 15;
    localparam int CMD_W    = 3;
    localparam int TGT_W    = 20;
    localparam int EXP_W    = 7;
    localparam int POS_W    = 19;
    localparam int STEP_W   = 7;
    localparam int FRAME_W  = 7;
    localparam int START_W  = 17;
    localparam int SIZE_W   = 11;
    localparam int BLASH_W  = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;

    // HFR fixed point format and the 99.0 start value, saturated to 15 bits.
    localparam int HFR_FRACTION_BITS = 8;
    localparam int HFR_INIT_RAW      = 99 << HFR_FRACTION_BITS;
    localparam logic [HFR_W-1:0] HFR_INIT =
        (HFR_INIT_RAW > ((1 << HFR_W) - 1)) ? {HFR_W{1'b1}} : HFR_W'(HFR_INIT_RAW);

    // Running mean divider: dividend is (n-1)*mean + hfr.
    localparam int DIV_W     = FRAME_W + HFR_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_STEPS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE_SECONDS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKLASH         = 3'd5;

    // Configuration reset values.
    localparam logic [START_W-1:0] RST_START_POSITION   = '0;
    localparam logic [SIZE_W-1:0]  RST_STEP_SIZE        = 11'd100;
    localparam logic [STEP_W-1:0]  RST_SWEEP_STEPS      = '0;
    localparam logic [FRAME_W-1:0] RST_FRAMES_PER_STEP  = 7'd1;
    localparam logic [EXP_W-1:0]   RST_EXPOSURE_SECONDS = 7'd1;
    localparam logic [BLASH_W-1:0] RST_BACKLASH         = '0;

    typedef enum logic [REQ_W-1:0] {
        REQ_START       = 3'd0,
        REQ_ABORT       = 3'd1,
        REQ_RESET_DONE  = 3'd2,
        REQ_REACHED     = 3'd3,
        REQ_IMAGE       = 3'd4
    } t_req;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE     = 3'd0,
        CMD_RESET    = 3'd1,
        CMD_MOVE     = 3'd2,
        CMD_EXPOSE   = 3'd3,
        CMD_FINISHED = 3'd4,
        CMD_ABORTED  = 3'd5
    } t_cmd;

    // Which position a move command targets.
    typedef enum logic [2:0] {
        TGT_NONE,
        TGT_BELOW_START,
        TGT_START,
        TGT_LOWEST,
        TGT_NEXT,
        TGT_BELOW_LOWEST
    } t_tgt_sel;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [HFR_W-1:0] hfr;
    } t_in_item;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [TGT_W-1:0] target_position;
        logic [EXP_W-1:0]        exposure_time;
        logic [HFR_W-1:0]        average_hfr;
        logic [POS_W-1:0]        best_position;
        logic [HFR_W-1:0]        best_hfr;
        logic [STEP_W-1:0]       step_index;
        logic [FRAME_W-1:0]      frame_index;
    } t_out_item;

    typedef struct packed {
        logic [START_W-1:0] start_position;
        logic [SIZE_W-1:0]  step_size;
        logic [STEP_W-1:0]  sweep_steps;
        logic [FRAME_W-1:0] frames_per_step;
        logic [EXP_W-1:0]   exposure_seconds;
        logic [BLASH_W-1:0] backlash;
    } t_cfg;

    // Controller to datapath commands.
    typedef struct packed {
        logic     load;
        logic     prep;
        logic     div_go;
        logic     commit;
        t_cmd     cmd;
        t_tgt_sel tgt;
        logic     clr_start;
        logic     clr_frame;
        logic     upd_mean;
        logic     upd_best;
        logic     inc_step;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             div_busy;
        logic             fc_less;
        logic             new_lower;
        logic             more_steps;
        logic             out_busy;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== src/autofocus_sweep_sequencer_top.sv =====
// Top level of the autofocus sweep sequencer: configuration registers and unit hookup.
// Sequencing: each accepted event passes through prepare and commit and gives one result
//   transfer; an image event while frames are being averaged also passes through the
//   23-step restoring divider that forms the running mean.
// Events are taken one at a time: a new event is stalled until the last one has committed.
// Reset: i_rst_n is synchronous and active low; it idles the sweep and loads all
//   configuration registers and sweep state with their documented reset values.
`default_nettype none

module autofocus_sweep_sequencer_top
    import afs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // Event input channel.
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_data,

    // Command result channel.
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data,

    // Configuration write channel.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  i_cfg_data
);

    t_cfg       r_cfg;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Configuration writes are always taken; the registers are read live by the
    // datapath, so a write between events takes effect on the next event.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_position   <= RST_START_POSITION;
            r_cfg.step_size        <= RST_STEP_SIZE;
            r_cfg.sweep_steps      <= RST_SWEEP_STEPS;
            r_cfg.frames_per_step  <= RST_FRAMES_PER_STEP;
            r_cfg.exposure_seconds <= RST_EXPOSURE_SECONDS;
            r_cfg.backlash         <= RST_BACKLASH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            // Each register keeps only its own width; unknown indexes are dropped.
            case (i_cfg_index)
                CFG_START_POSITION:   r_cfg.start_position   <= i_cfg_data[START_W-1:0];
                CFG_STEP_SIZE:        r_cfg.step_size        <= i_cfg_data[SIZE_W-1:0];
                CFG_SWEEP_STEPS:      r_cfg.sweep_steps      <= i_cfg_data[STEP_W-1:0];
                CFG_FRAMES_PER_STEP:  r_cfg.frames_per_step  <= i_cfg_data[FRAME_W-1:0];
                CFG_EXPOSURE_SECONDS: r_cfg.exposure_seconds <= i_cfg_data[EXP_W-1:0];
                CFG_BACKLASH:         r_cfg.backlash         <= i_cfg_data[BLASH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The controller walks each event through prepare, optional divide and commit,
    // and keeps the sweep phase. The commit waits while the result register still
    // holds an untaken transfer, so no result is ever overwritten.
    afs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the sweep state, works out positions and the running
    // mean, and drives the registered result transfer.
    afs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_cfg       (r_cfg),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== src/afs_dpath.sv =====
// Datapath: sweep state, position arithmetic, running mean divider and result register.
`default_nettype none

module afs_dpath
    import afs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_status      o_status,
    input  wire t_cfg       i_cfg,
    input  wire t_in_item   i_in_data,
    input  wire logic       i_out_stall,
    output logic            o_out_valid,
    output t_out_item       o_out_data
);

    // Captured event.
    logic [REQ_W-1:0]   r_req;
    logic [HFR_W-1:0]   r_hfr;

    // Architectural sweep state.
    logic [STEP_W-1:0]  r_step,       n_step;
    logic [FRAME_W-1:0] r_fc,         n_fc;
    logic [HFR_W-1:0]   r_mean,       n_mean;
    logic [HFR_W-1:0]   r_lowest_hfr, n_lowest_hfr;
    logic [POS_W-1:0]   r_lowest_pos, n_lowest_pos;

    // Working registers filled in the prepare cycle.
    logic [POS_W-1:0]   r_pos;
    logic [FRAME_W-1:0] r_fc_new;

    // Restoring divider.
    logic [DIV_W-1:0]     r_div_num;
    logic [FRAME_W-1:0]   r_div_rem;
    logic [FRAME_W-1:0]   r_div_d;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic                 r_out_valid;
    t_out_item            r_out;

    logic [FRAME_W-1:0]   fc_inc;
    logic [FRAME_W-1:0]   fc_new;
    logic [FRAME_W-1:0]   fc_prev;
    logic [DIV_W-1:0]     dividend;
    logic [POS_W-1:0]     pos_now;
    logic [FRAME_W:0]     rem_sh;
    logic                 q_bit;
    logic [FRAME_W-1:0]   frames;
    logic [HFR_W-1:0]     mean_new;
    logic [TGT_W-1:0]     target;

    // Prepare cycle: one small multiply and add for each operand.
    always_comb begin
        fc_inc   = r_fc + FRAME_W'(1);
        fc_new   = (fc_inc == '0) ? FRAME_W'(1) : fc_inc;
        fc_prev  = fc_new - FRAME_W'(1);
        dividend = DIV_W'(fc_prev * r_mean) + DIV_W'(r_hfr);
        pos_now  = POS_W'(i_cfg.start_position) + POS_W'(r_step * i_cfg.step_size);
    end

    // One quotient bit a cycle.
    always_comb begin
        rem_sh = {r_div_rem, r_div_num[DIV_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_div_d});
    end

    assign frames   = (i_cfg.frames_per_step == '0) ? FRAME_W'(1) : i_cfg.frames_per_step;
    assign mean_new = r_div_num[HFR_W-1:0];

    // Next architectural state at commit.
    always_comb begin
        n_step       = r_step;
        n_fc         = r_fc;
        n_mean       = r_mean;
        n_lowest_hfr = r_lowest_hfr;
        n_lowest_pos = r_lowest_pos;
        if (i_cmd.clr_start) begin
            n_step       = '0;
            n_lowest_hfr = HFR_INIT;
            n_lowest_pos = POS_W'(i_cfg.start_position);
        end
        if (i_cmd.inc_step) begin
            n_step = r_step + STEP_W'(1);
        end
        if (i_cmd.clr_frame) begin
            n_fc   = '0;
            n_mean = HFR_INIT;
        end
        if (i_cmd.upd_mean) begin
            n_fc   = r_fc_new;
            n_mean = mean_new;
        end
        if (i_cmd.upd_best) begin
            n_lowest_hfr = mean_new;
            n_lowest_pos = r_pos;
        end
    end

    always_comb begin
        case (i_cmd.tgt)
            TGT_BELOW_START:
                target = TGT_W'(i_cfg.start_position) - TGT_W'(i_cfg.backlash);
            TGT_START:
                target = TGT_W'(i_cfg.start_position);
            TGT_LOWEST:
                target = TGT_W'(r_lowest_pos);
            TGT_NEXT:
                target = TGT_W'(r_pos) + TGT_W'(i_cfg.step_size);
            TGT_BELOW_LOWEST:
                target = TGT_W'(n_lowest_pos) - TGT_W'(i_cfg.backlash);
            default:
                target = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= '0;
            r_fc         <= '0;
            r_mean       <= HFR_INIT;
            r_lowest_hfr <= HFR_INIT;
            r_lowest_pos <= '0;
            r_div_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.prep && i_cmd.div_go) begin
                r_div_cnt <= DIV_CNT_W'(DIV_W);
            end else if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
            end
            if (i_cmd.commit) begin
                r_step       <= n_step;
                r_fc         <= n_fc;
                r_mean       <= n_mean;
                r_lowest_hfr <= n_lowest_hfr;
                r_lowest_pos <= n_lowest_pos;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_data.req_type;
            r_hfr <= i_in_data.hfr;
        end
        if (i_cmd.prep) begin
            r_pos     <= pos_now;
            r_fc_new  <= fc_new;
            r_div_num <= dividend;
            r_div_rem <= '0;
            r_div_d   <= fc_new;
        end else if (r_div_cnt != '0) begin
            r_div_num <= {r_div_num[DIV_W-2:0], q_bit};
            r_div_rem <= q_bit ? FRAME_W'(rem_sh - {1'b0, r_div_d}) : rem_sh[FRAME_W-1:0];
        end
        if (i_cmd.commit) begin
            r_out.command         <= i_cmd.cmd;
            r_out.target_position <= (i_cmd.cmd == CMD_MOVE) ? target : '0;
            r_out.exposure_time   <= (i_cmd.cmd == CMD_EXPOSE) ? i_cfg.exposure_seconds : '0;
            r_out.average_hfr     <= n_mean;
            r_out.best_position   <= n_lowest_pos;
            r_out.best_hfr        <= n_lowest_hfr;
            r_out.step_index      <= n_step;
            r_out.frame_index     <= n_fc;
        end
    end

    always_comb begin
        o_status.req        = r_req;
        o_status.div_busy   = (r_div_cnt != '0);
        o_status.fc_less    = (r_fc_new < frames);
        o_status.new_lower  = (mean_new < r_lowest_hfr);
        o_status.more_steps = (r_step < i_cfg.sweep_steps);
        o_status.out_busy   = r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("result register not loaded after commit");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div_cnt != '0) |-> (r_div_d != '0))
        else $error("divider running with zero divisor");
`endif

endmodule

`default_nettype wire

// ===== src/afs_ctrl.sv =====
// Controller: event sequencing and sweep phase state machine.
`default_nettype none

module afs_ctrl
    import afs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_COMMIT
    } t_state;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_WAIT_RESET,
        PH_WAIT_PRE_START,
        PH_WAIT_START,
        PH_WAIT_FRAME,
        PH_WAIT_NEXT,
        PH_WAIT_PRE_BEST,
        PH_WAIT_BEST,
        PH_WAIT_FINAL
    } t_phase;

    t_state  r_state, n_state;
    t_phase  r_phase, n_phase;
    logic    accept;
    logic    averaging;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign averaging  = (i_status.req == REQ_IMAGE) && (r_phase == PH_WAIT_FRAME);

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        o_cmd         = '0;
        o_cmd.cmd     = CMD_NONE;
        o_cmd.tgt     = TGT_NONE;
        o_cmd.load    = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep   = 1'b1;
                o_cmd.div_go = averaging;
                n_state      = averaging ? S_DIV : S_COMMIT;
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                    case (i_status.req)
                        REQ_START: begin
                            o_cmd.clr_start = 1'b1;
                            o_cmd.cmd       = CMD_RESET;
                            n_phase         = PH_WAIT_RESET;
                        end
                        REQ_ABORT: begin
                            if (r_phase != PH_IDLE) begin
                                o_cmd.cmd = CMD_ABORTED;
                                n_phase   = PH_IDLE;
                            end
                        end
                        REQ_RESET_DONE: begin
                            if (r_phase == PH_WAIT_RESET) begin
                                o_cmd.cmd = CMD_MOVE;
                                o_cmd.tgt = TGT_BELOW_START;
                                n_phase   = PH_WAIT_PRE_START;
                            end
                        end
                        REQ_REACHED: begin
                            if (r_phase == PH_WAIT_PRE_START) begin
                                o_cmd.cmd = CMD_MOVE;
                                o_cmd.tgt = TGT_START;
                                n_phase   = PH_WAIT_START;
                            end else if (r_phase == PH_WAIT_START
                                         || r_phase == PH_WAIT_NEXT) begin
                                o_cmd.clr_frame = 1'b1;
                                o_cmd.cmd       = CMD_EXPOSE;
                                n_phase         = PH_WAIT_FRAME;
                            end else if (r_phase == PH_WAIT_PRE_BEST) begin
                                o_cmd.cmd = CMD_MOVE;
                                o_cmd.tgt = TGT_LOWEST;
                                n_phase   = PH_WAIT_BEST;
                            end else if (r_phase == PH_WAIT_BEST) begin
                                o_cmd.cmd = CMD_EXPOSE;
                                n_phase   = PH_WAIT_FINAL;
                            end
                        end
                        REQ_IMAGE: begin
                            if (r_phase == PH_WAIT_FRAME) begin
                                o_cmd.upd_mean = 1'b1;
                                if (i_status.fc_less) begin
                                    o_cmd.cmd = CMD_EXPOSE;
                                end else begin
                                    o_cmd.upd_best = i_status.new_lower;
                                    o_cmd.cmd      = CMD_MOVE;
                                    if (i_status.more_steps) begin
                                        o_cmd.inc_step = 1'b1;
                                        o_cmd.tgt      = TGT_NEXT;
                                        n_phase        = PH_WAIT_NEXT;
                                    end else begin
                                        o_cmd.tgt = TGT_BELOW_LOWEST;
                                        n_phase   = PH_WAIT_PRE_BEST;
                                    end
                                end
                            end else if (r_phase == PH_WAIT_FINAL) begin
                                o_cmd.cmd = CMD_FINISHED;
                                n_phase   = PH_IDLE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_IDLE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

`ifndef SYNTHESIS
    a_accept_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_PREP))
        else $error("accepted event did not enter prepare");

    a_phase_only_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cmd.commit |=> $stable(r_phase))
        else $error("sweep phase changed outside commit");

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_status.div_busy) |=> (r_state == S_DIV))
        else $error("left divide before the quotient was complete");
`endif

endmodule

`default_nettype wire
